// ===== sv/rcba_pkg.sv =====
// Shared types and constants for the read coverage bin accumulator.
// Holds the state encoding, register indexes and the divider request/response
// structs. No dependencies.
package rcba_pkg;

  localparam int NUM_BINS_DEF = 65536;
  localparam int DATA_W       = 32;
  localparam int DIV_W        = 48;
  localparam int DVSR_W       = 16;
  localparam int CFG_AW       = 5;

  localparam logic [15:0] BIN_SIZE_RST     = 16'd100;
  localparam logic [30:0] CHROM_LENGTH_RST = 31'h7fff_ffff;
  localparam logic [31:0] NORM_WEIGHT_RST  = 32'h0001_0000;

  typedef enum logic [2:0] {
    REG_BIN_SIZE     = 3'd0,
    REG_CENTER_WIDTH = 3'd1,
    REG_CHROM_LENGTH = 3'd2,
    REG_MAP_ENABLE   = 3'd3,
    REG_MAP_THRESH   = 3'd4,
    REG_NORM_ENABLE  = 3'd5,
    REG_NORM_WEIGHT  = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_ORDER,
    ST_ADD_CENTER,
    ST_ADD_CLAMP,
    ST_DIV_S,
    ST_DIV_E,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_RB_RD,
    ST_RB_SCALE,
    ST_MAP_DIV,
    ST_NORM_MUL,
    ST_NORM_SAT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/rcba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rcba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rcba_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses rcba_pkg for widths and the request/response structs.
module rcba_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rcba_pkg::div_req_t req,
  output rcba_pkg::div_rsp_t rsp
);

  import rcba_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [DVSR_W:0]   rem_sh;
  logic [DVSR_W:0]   rem_sub;
  logic              q_bit;

  // shift in the next dividend bit and try a subtract
  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr_r};
  assign q_bit   = (rem_sh >= {1'b0, dvsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIV_W-2:0], q_bit};
      rem_nxt = q_bit ? rem_sub[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(req.start))
    else $error("divider went busy without a start");
`endif

endmodule

// ===== sv/read_coverage_bin_accumulator.sv =====
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_ready  | action, end_one, end_two, is_duplicate,
//         |           |                    | read_weight, bin_index, bin_mappable_length
// out_    | output    | out_valid/out_ready| bin_value
// cfg     | input     | apb psel/penable   | paddr, pwdata, prdata
//
// One item at a time. An add runs two bin-index divisions in the shared divider,
// then one bin memory read-modify-write per cycle over the covered bins. A readout
// uses the divider only when the mappability correction runs. After reset the bin
// memory is cleared, one entry a cycle, with in_ready low. A result waiting on
// out_ready does not stop the next item being taken.
// Depends on rcba_pkg, rcba_ram and rcba_div.
module read_coverage_bin_accumulator #(
  parameter int NUM_BINS = rcba_pkg::NUM_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [30:0] in_end_one,
  input  logic [30:0] in_end_two,
  input  logic        in_is_duplicate,
  input  logic [15:0] in_read_weight,
  input  logic [15:0] in_bin_index,
  input  logic [15:0] in_bin_mappable_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_bin_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import rcba_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam logic [IDX_W-1:0] LAST_BIN   = IDX_W'(NUM_BINS - 1);
  localparam logic [30:0]      LAST_BIN31 = 31'(NUM_BINS - 1);
  localparam logic [31:0]      NUM_BINS32 = 32'(NUM_BINS);

  // configuration registers
  logic [15:0] bin_size_r;
  logic [15:0] center_width_r;
  logic [30:0] chrom_length_r;
  logic        map_en_r;
  logic [15:0] map_thr_r;
  logic        norm_en_r;
  logic [31:0] norm_weight_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_size_r     <= BIN_SIZE_RST;
      center_width_r <= '0;
      chrom_length_r <= CHROM_LENGTH_RST;
      map_en_r       <= 1'b0;
      map_thr_r      <= '0;
      norm_en_r      <= 1'b0;
      norm_weight_r  <= NORM_WEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BIN_SIZE:     bin_size_r     <= pwdata[15:0];
        REG_CENTER_WIDTH: center_width_r <= pwdata[15:0];
        REG_CHROM_LENGTH: chrom_length_r <= pwdata[30:0];
        REG_MAP_ENABLE:   map_en_r       <= pwdata[0];
        REG_MAP_THRESH:   map_thr_r      <= pwdata[15:0];
        REG_NORM_ENABLE:  norm_en_r      <= pwdata[0];
        REG_NORM_WEIGHT:  norm_weight_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BIN_SIZE:     prdata = {16'b0, bin_size_r};
      REG_CENTER_WIDTH: prdata = {16'b0, center_width_r};
      REG_CHROM_LENGTH: prdata = {1'b0, chrom_length_r};
      REG_MAP_ENABLE:   prdata = {31'b0, map_en_r};
      REG_MAP_THRESH:   prdata = {16'b0, map_thr_r};
      REG_NORM_ENABLE:  prdata = {31'b0, norm_en_r};
      REG_NORM_WEIGHT:  prdata = norm_weight_r;
      default:          prdata = '0;
    endcase
  end

  // datapath and control state
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   bin_r, bin_nxt;
  logic [IDX_W-1:0]   bin_last_r, bin_last_nxt;
  logic [30:0]        bin_first_r, bin_first_nxt;
  logic signed [33:0] pos_s_r, pos_s_nxt;
  logic signed [33:0] pos_e_r, pos_e_nxt;
  logic [31:0]        v_r, v_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_bin_value_r, out_bin_value_nxt;

  logic [30:0]        end_one_r, end_two_r;
  logic [15:0]        weight_r;
  logic [IDX_W-1:0]   idx_r;
  logic [15:0]        mlen_r;

  // bin memory and divider hookup
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               in_xfer;
  logic [15:0]        bs_eff;
  logic [30:0]        lo_pos, hi_pos;
  logic signed [33:0] cw_s;
  logic signed [33:0] ctr_sum, ctr_half;
  logic signed [33:0] lim, s_cl, e_cl;
  logic [30:0]        q_last;
  logic [32:0]        acc_sum;
  logic [47:0]        map_prod;
  logic [63:0]        norm_prod;
  logic               map_hit;
  logic [31:0]        in_idx32;

  assign in_xfer  = in_valid && in_ready;
  assign bs_eff   = (bin_size_r == 16'd0) ? 16'd1 : bin_size_r;
  assign lo_pos   = (end_one_r < end_two_r) ? end_one_r : end_two_r;
  assign hi_pos   = (end_one_r < end_two_r) ? end_two_r : end_one_r;
  assign cw_s     = $signed({18'b0, center_width_r});
  assign ctr_sum  = pos_s_r + pos_e_r - cw_s;
  // halve, truncating toward zero
  assign ctr_half = (ctr_sum + $signed({33'b0, ctr_sum[33]})) >>> 1;
  assign lim      = $signed({3'b0, chrom_length_r}) - 34'sd1;
  assign s_cl     = pos_s_r[33] ? 34'sd0 : pos_s_r;
  assign e_cl     = (pos_e_r > lim) ? lim : pos_e_r;
  assign q_last   = (div_rsp.quotient > {17'b0, LAST_BIN31}) ? LAST_BIN31
                                                             : div_rsp.quotient[30:0];
  assign acc_sum  = {1'b0, ram_rdata} + {17'b0, weight_r};
  assign map_prod = {16'b0, v_r} * {32'b0, bs_eff};
  assign norm_prod = {32'b0, v_r} * {32'b0, norm_weight_r};
  assign map_hit  = map_en_r && (mlen_r > map_thr_r);
  assign in_idx32 = {16'b0, in_bin_index};

  always_comb begin
    state_nxt         = state_r;
    bin_nxt           = bin_r;
    bin_last_nxt      = bin_last_r;
    bin_first_nxt     = bin_first_r;
    pos_s_nxt         = pos_s_r;
    pos_e_nxt         = pos_e_r;
    v_nxt             = v_r;
    prod_nxt          = prod_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_bin_value_nxt = out_bin_value_r;
    ram_we            = 1'b0;
    ram_waddr         = bin_r;
    ram_wdata         = '0;
    ram_re            = 1'b0;
    ram_raddr         = bin_r;
    div_req.start     = 1'b0;
    div_req.dividend  = {17'b0, s_cl[30:0]};
    div_req.divisor   = bs_eff;
    in_ready          = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        bin_nxt = bin_r + 1'b1;
        if (bin_r == LAST_BIN) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action) begin
            if (in_idx32 >= NUM_BINS32) begin
              v_nxt     = '0;
              state_nxt = ST_OUT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = in_idx32[IDX_W-1:0];
              state_nxt = ST_RB_RD;
            end
          end else if (!in_is_duplicate) begin
            state_nxt = ST_ADD_ORDER;
          end
        end
      end
      ST_ADD_ORDER: begin
        pos_s_nxt = $signed({3'b0, lo_pos});
        pos_e_nxt = $signed({3'b0, hi_pos});
        state_nxt = ST_ADD_CENTER;
      end
      ST_ADD_CENTER: begin
        if (center_width_r != 16'd0) begin
          pos_s_nxt = ctr_half;
          pos_e_nxt = ctr_half + cw_s;
        end
        state_nxt = ST_ADD_CLAMP;
      end
      ST_ADD_CLAMP: begin
        pos_e_nxt = e_cl;
        if (e_cl < s_cl) begin
          state_nxt = ST_IDLE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_S;
        end
      end
      ST_DIV_S: begin
        div_req.dividend = {17'b0, pos_e_r[30:0]};
        if (div_rsp.done) begin
          bin_first_nxt = div_rsp.quotient[30:0];
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_E;
        end
      end
      ST_DIV_E: begin
        if (div_rsp.done) begin
          if (bin_first_r > q_last) begin
            state_nxt = ST_IDLE;
          end else begin
            bin_nxt      = bin_first_r[IDX_W-1:0];
            bin_last_nxt = q_last[IDX_W-1:0];
            state_nxt    = ST_ADD_RD;
          end
        end
      end
      ST_ADD_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        // read data belongs to bin_r; fetch the next bin in the same cycle
        ram_we    = 1'b1;
        ram_wdata = acc_sum[32] ? '1 : acc_sum[31:0];
        if (bin_r == bin_last_r) begin
          state_nxt = ST_IDLE;
        end else begin
          bin_nxt   = bin_r + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = bin_r + 1'b1;
        end
      end
      ST_RB_RD: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        v_nxt     = ram_rdata;
        state_nxt = ST_RB_SCALE;
      end
      ST_RB_SCALE: begin
        if (map_hit) begin
          div_req.start    = 1'b1;
          div_req.dividend = map_prod;
          div_req.divisor  = mlen_r;
          state_nxt        = ST_MAP_DIV;
        end else begin
          state_nxt = ST_NORM_MUL;
        end
      end
      ST_MAP_DIV: begin
        if (div_rsp.done) begin
          v_nxt     = (div_rsp.quotient[47:32] != 16'd0) ? '1 : div_rsp.quotient[31:0];
          state_nxt = ST_NORM_MUL;
        end
      end
      ST_NORM_MUL: begin
        if (norm_en_r && (v_r != 32'd0)) begin
          prod_nxt  = norm_prod;
          state_nxt = ST_NORM_SAT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_NORM_SAT: begin
        v_nxt     = (prod_r[63:48] != 16'd0) ? '1 : prod_r[47:16];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_bin_value_nxt = v_r;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      bin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bin_r       <= bin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_last_r      <= bin_last_nxt;
    bin_first_r     <= bin_first_nxt;
    pos_s_r         <= pos_s_nxt;
    pos_e_r         <= pos_e_nxt;
    v_r             <= v_nxt;
    prod_r          <= prod_nxt;
    out_bin_value_r <= out_bin_value_nxt;
    if (in_xfer) begin
      end_one_r <= in_end_one;
      end_two_r <= in_end_two;
      weight_r  <= in_read_weight;
      idx_r     <= in_idx32[IDX_W-1:0];
      mlen_r    <= in_bin_mappable_length;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_value = out_bin_value_r;

  rcba_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rcba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

`ifndef ASSERT_OFF
  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the output state");

  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD_WR) |-> (bin_r <= bin_last_r))
    else $error("bin walk passed its last bin");

  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write of the same bin in one cycle");

  a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !div_rsp.busy)
    else $error("item taken while divider still busy");
`endif

endmodule
